// ----- rtl/dda_line_rasterizer_macros.svh -----
// Assertion macros used by the checker file of the line rasterizer.
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dda: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DDA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dda: next-cycle check failed");

`endif

// ----- rtl/dda_pkg.sv -----
`default_nettype none

package dda_pkg;

  localparam int COORD_BITS = 11;
  localparam int FRAC_BITS  = 20;

  // Accumulator: sign, integer and fraction bits.
  localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
  // Increment: sign plus magnitude up to 1.0.
  localparam int INC_W = FRAC_BITS + 2;
  // Divider iteration counter.
  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  localparam logic [ACC_W-1:0] HALF_ULP = ACC_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_X,
    S_DIV_Y
  } dda_state_e;

  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] mag;
    logic [COORD_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [FRAC_BITS:0]   quo;
  } div_rsp_t;

  // Round half up and keep the integer coordinate bits.
  function automatic logic [COORD_BITS-1:0] round_px(logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] sum;
    sum = acc + HALF_ULP;
    return sum[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dda_line_rasterizer.sv -----
`default_nettype none

// Channel | Direction | Handshake                | Payload
// in      | sink      | in_valid_i / in_stall_o  | func, start_x, start_y, end_x, end_y
// out     | source    | out_valid_o / out_stall_i| pixel_x, pixel_y, last
//
// A step item on an active line has its pixel registered on the accepting edge.
// A start item of nonzero length runs the shared divider twice, one quotient
// bit per cycle, first for x and then for y: the first pixel is registered
// as the y division finishes, and no item is taken meanwhile.
// A zero-length start emits its pixel on the accepting edge.
// Input is taken only while idle and the output register is empty or draining.
// Reset clears the sequencer, the active flag and the output valid.
module dda_line_rasterizer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic                           func_i,
  input  wire logic [dda_pkg::COORD_BITS-1:0] start_x_i,
  input  wire logic [dda_pkg::COORD_BITS-1:0] start_y_i,
  input  wire logic [dda_pkg::COORD_BITS-1:0] end_x_i,
  input  wire logic [dda_pkg::COORD_BITS-1:0] end_y_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [dda_pkg::COORD_BITS-1:0] pixel_x_o,
  output      logic [dda_pkg::COORD_BITS-1:0] pixel_y_o,
  output      logic                           last_o
);
  import dda_pkg::*;

  dda_state_e state_q, state_d;

  logic                  active_q, active_d;
  logic [COORD_BITS-1:0] steps_left_q, steps_left_d;
  logic [COORD_BITS-1:0] steps_q;
  logic [COORD_BITS-1:0] mag_y_q;
  logic                  neg_x_q, neg_y_q;
  logic [ACC_W-1:0]      acc_x_q, acc_y_q;
  logic [INC_W-1:0]      inc_x_q, inc_y_q;

  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
  logic                  last_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                  in_ready, in_acc, is_start, is_step, zero_len;
  logic [COORD_BITS:0]   dx, dy, ndx, ndy;
  logic [COORD_BITS-1:0] adx, ady, steps_c;
  logic [ACC_W-1:0]      acc_x_src, acc_y_src;
  logic [INC_W-1:0]      quo_ext, inc_new;
  logic                  out_load, out_last;

  // Accept only when idle and the output slot is free or being taken
  assign in_ready   = (state_q == S_IDLE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = ~in_ready;
  assign in_acc     = in_valid_i && in_ready;
  assign is_start   = in_acc && !func_i;
  assign is_step    = in_acc && func_i && active_q;

  // Deltas, magnitudes and the step count
  assign dx       = {1'b0, end_x_i} - {1'b0, start_x_i};
  assign dy       = {1'b0, end_y_i} - {1'b0, start_y_i};
  assign ndx      = -dx;
  assign ndy      = -dy;
  assign adx      = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
  assign ady      = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
  assign steps_c  = (adx > ady) ? adx : ady;
  assign zero_len = (steps_c == '0);

  // Signed increment from the divider quotient
  assign quo_ext = {1'b0, div_rsp.quo};
  assign inc_new = ((state_q == S_DIV_X) ? neg_x_q : neg_y_q) ? -quo_ext : quo_ext;

  // Accumulator source: load on start, add on step, hold otherwise
  always_comb begin
    acc_x_src = acc_x_q;
    acc_y_src = acc_y_q;
    if (is_start) begin
      acc_x_src = {1'b0, start_x_i, {FRAC_BITS{1'b0}}};
      acc_y_src = {1'b0, start_y_i, {FRAC_BITS{1'b0}}};
    end else if (is_step) begin
      acc_x_src = acc_x_q + {{(ACC_W-INC_W){inc_x_q[INC_W-1]}}, inc_x_q};
      acc_y_src = acc_y_q + {{(ACC_W-INC_W){inc_y_q[INC_W-1]}}, inc_y_q};
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (is_start && !zero_len) state_d = S_DIV_X;
      S_DIV_X: if (div_rsp.done) state_d = S_DIV_Y;
      S_DIV_Y: if (div_rsp.done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: divider requests and output register load
  always_comb begin
    div_req.start   = 1'b0;
    div_req.mag     = mag_y_q;
    div_req.divisor = steps_q;
    out_load        = 1'b0;
    out_last        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        div_req.mag     = adx;
        div_req.divisor = steps_c;
        div_req.start   = is_start && !zero_len;
        out_load        = (is_start && zero_len) || is_step;
        out_last        = is_start || (steps_left_q == COORD_BITS'(1));
      end
      S_DIV_X: begin
        div_req.start = div_rsp.done;
      end
      S_DIV_Y: begin
        out_load = div_rsp.done;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Line bookkeeping
  always_comb begin
    active_d     = active_q;
    steps_left_d = steps_left_q;
    if (is_start) begin
      active_d     = !zero_len;
      steps_left_d = steps_c;
    end else if (is_step) begin
      active_d     = (steps_left_q != COORD_BITS'(1));
      steps_left_d = steps_left_q - COORD_BITS'(1);
    end
  end

  // Output register: load a pixel, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      active_q     <= 1'b0;
      steps_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      active_q     <= active_d;
      steps_left_q <= steps_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_x_q <= acc_x_src;
    acc_y_q <= acc_y_src;
    if (is_start) begin
      steps_q <= steps_c;
      mag_y_q <= ady;
      neg_x_q <= dx[COORD_BITS];
      neg_y_q <= dy[COORD_BITS];
    end
    if ((state_q == S_DIV_X) && div_rsp.done) begin
      inc_x_q <= inc_new;
    end
    if ((state_q == S_DIV_Y) && div_rsp.done) begin
      inc_y_q <= inc_new;
    end
    if (out_load) begin
      pixel_x_q <= round_px(acc_x_src);
      pixel_y_q <= round_px(acc_y_src);
      last_q    <= out_last;
    end
  end

  dda_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = pixel_x_q;
  assign pixel_y_o   = pixel_y_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ----- rtl/dda_div.sv -----
`default_nettype none

// Restoring divider: (mag << FRAC_BITS) / divisor with mag <= divisor.
// One quotient bit per cycle; the quotient has FRAC_BITS+1 bits.
module dda_div (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dda_pkg::div_req_t req_i,
  output dda_pkg::div_rsp_t    rsp_o
);
  import dda_pkg::*;

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [COORD_BITS:0]   rem_q, rem_d;
  logic [COORD_BITS-1:0] dvs_q, dvs_d;
  logic [FRAC_BITS-1:0]  quo_q, quo_d;

  logic [COORD_BITS+1:0] trial;
  logic                  ge;
  logic [COORD_BITS:0]   rem_sel;
  logic                  last_iter;

  // Trial subtract of the shared unit
  assign trial     = {1'b0, rem_q} - {2'b00, dvs_q};
  assign ge        = ~trial[COORD_BITS+1];
  assign rem_sel   = ge ? trial[COORD_BITS:0] : rem_q;
  assign last_iter = busy_q && (cnt_q == CNT_W'(FRAC_BITS));

  assign rsp_o.done = last_iter;
  assign rsp_o.quo  = {quo_q, ge};

  // Load a new division or advance one bit
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, req_i.mag};
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      cnt_d  = cnt_q + CNT_W'(1);
      rem_d  = {rem_sel[COORD_BITS-1:0], 1'b0};
      quo_d  = {quo_q[FRAC_BITS-2:0], ge};
      if (last_iter) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

endmodule

`default_nettype wire

// ----- rtl/dda_chk.sv -----
`default_nettype none

`include "dda_line_rasterizer_macros.svh"

// Port-level checks on the line rasterizer.
module dda_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic func_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic [dda_pkg::COORD_BITS-1:0] pixel_x_o,
  input wire logic [dda_pkg::COORD_BITS-1:0] pixel_y_o,
  input wire logic last_o
);

  // A stalled transaction stays offered
  `DDA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // A stalled payload does not change
  `DDA_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i,
    $stable(pixel_x_o) && $stable(pixel_y_o) && $stable(last_o))

  // A start either emits at once or keeps the block busy dividing
  `DDA_ASSERT_NXT(a_start_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && !func_i,
    in_stall_o || out_valid_o)

endmodule

bind dda_line_rasterizer dda_chk u_dda_chk (.*);

`default_nettype wire

// ----- verif/dda_line_rasterizer_tb.sv -----
`timescale 1ns / 100ps

module testbench;
  import dda_pkg::*;

  localparam int NUM_DIR      = 24;
  localparam int RAND_PIXELS  = 1350;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int IDLE_PCT     = 29;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [INC_W-1:0]      inc_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  // How a stimulus row is checked: by the predictor, as no pixel, or as a typed pixel.
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_NONE,
    CHK_PIXEL
  } chk_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  typedef struct packed {
    op_e    op;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    chk_e   chk;
    coord_t px;
    coord_t py;
    logic   last;
  } row_t;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   func_i      = 1'b0;
  coord_t start_x_i   = '0;
  coord_t start_y_i   = '0;
  coord_t end_x_i     = '0;
  coord_t end_y_i     = '0;
  logic   out_stall_i = 1'b0;
  logic   in_stall_o;
  logic   out_valid_o;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  logic   last_o;

  dda_line_rasterizer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_x_o   (pixel_x_o),
    .pixel_y_o   (pixel_y_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Line walker state mirrored from the block
  logic   line_on    = 1'b0;
  acc_t   line_acc_x = '0;
  acc_t   line_acc_y = '0;
  inc_t   line_inc_x = '0;
  inc_t   line_inc_y = '0;
  coord_t line_left  = '0;

  pixel_t expected_pixels [$];
  int     fail_cnt     = 0;
  int     produced_cnt = 0;
  bit     calm         = 1'b0;
  bit     hold_req     = 1'b0;
  bit     hold_done    = 1'b0;
  int     hold_cnt     = 0;
  row_t   dir_rows [NUM_DIR];

  function automatic coord_t round_half_up(acc_t a);
    acc_t s;
    s = a + HALF_ULP;
    return s[FRAC_BITS +: COORD_BITS];
  endfunction

  // Signed slope, truncated toward zero.
  function automatic inc_t slope_of(longint delta, longint span);
    longint q;
    q = ((delta < 0 ? -delta : delta) << FRAC_BITS) / span;
    return inc_t'(delta < 0 ? -q : q);
  endfunction

  // Advance the mirrored line by one transaction; return 1 when a pixel comes out.
  function automatic bit raster_next(input op_e op, input coord_t sx, input coord_t sy,
                                     input coord_t ex, input coord_t ey, output pixel_t pix);
    longint dx, dy, adx, ady, span;
    pix = '0;
    if (op == OP_START) begin
      dx   = longint'(ex) - longint'(sx);
      dy   = longint'(ey) - longint'(sy);
      adx  = dx < 0 ? -dx : dx;
      ady  = dy < 0 ? -dy : dy;
      span = adx > ady ? adx : ady;
      line_acc_x = {1'b0, sx, {FRAC_BITS{1'b0}}};
      line_acc_y = {1'b0, sy, {FRAC_BITS{1'b0}}};
      if (span == 0) begin
        line_inc_x = '0;
        line_inc_y = '0;
        line_left  = '0;
        line_on    = 1'b0;
      end else begin
        line_inc_x = slope_of(dx, span);
        line_inc_y = slope_of(dy, span);
        line_left  = coord_t'(span);
        line_on    = 1'b1;
      end
      pix = '{round_half_up(line_acc_x), round_half_up(line_acc_y), span == 0};
      return 1'b1;
    end
    // Drop steps that arrive with no line in progress
    if (!line_on || line_left == 0) begin
      line_on = 1'b0;
      return 1'b0;
    end
    line_acc_x = line_acc_x + line_inc_x;
    line_acc_y = line_acc_y + line_inc_y;
    line_left  = line_left - 1'b1;
    if (line_left == 0) line_on = 1'b0;
    pix = '{round_half_up(line_acc_x), round_half_up(line_acc_y), line_left == 0};
    return 1'b1;
  endfunction

  // Offer one transaction after a random gap and log its expected pixel on acceptance.
  task automatic send_item(input row_t r, output bit produced);
    pixel_t pix;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= r.op;
    start_x_i  <= r.sx;
    start_y_i  <= r.sy;
    end_x_i    <= r.ex;
    end_y_i    <= r.ey;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    produced = raster_next(r.op, r.sx, r.sy, r.ex, r.ey, pix);
    case (r.chk)
      CHK_PREDICT: if (produced) expected_pixels.push_back(pix);
      CHK_PIXEL:   expected_pixels.push_back(pixel_t'{r.px, r.py, r.last});
      default: ;
    endcase
  endtask

  // Check each pixel transaction, then pick the next stall value
  always @(posedge clk_i) begin
    pixel_t exp_pix;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel x=%0d y=%0d last=%0d", pixel_x_o, pixel_y_o, last_o);
          fail_cnt++;
        end else begin
          exp_pix = expected_pixels.pop_front();
          if (pixel_x_o !== exp_pix.x) begin
            $error("pixel_x mismatch: expected %0d, actual %0d", exp_pix.x, pixel_x_o);
            fail_cnt++;
          end
          if (pixel_y_o !== exp_pix.y) begin
            $error("pixel_y mismatch: expected %0d, actual %0d", exp_pix.y, pixel_y_o);
            fail_cnt++;
          end
          if (last_o !== exp_pix.last) begin
            $error("last mismatch: expected %0d, actual %0d", exp_pix.last, last_o);
            fail_cnt++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    row_t   r;
    bit     got;
    coord_t sx, sy, ex, ey;
    int     dx, dy, span, walk, pick;
    bit     wide;

    dir_rows = '{
      // step right after reset: nothing to emit
      '{OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_NONE,  11'd0,    11'd0,    1'b0},
      // zero-length lines at both corners, with a step between them that finds no line
      '{OP_START, 11'd0,    11'd0,    11'd0,    11'd0,    CHK_PIXEL, 11'd0,    11'd0,    1'b1},
      '{OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_NONE,  11'd0,    11'd0,    1'b0},
      '{OP_START, 11'd2047, 11'd2047, 11'd2047, 11'd2047, CHK_PIXEL, 11'd2047, 11'd2047, 1'b1},
      // full diagonal, cut short by a new line
      '{OP_START, 11'd0,    11'd0,    11'd2047, 11'd2047, CHK_PIXEL, 11'd0,    11'd0,    1'b0},
      '{OP_STEP,  11'd2047, 11'd2047, 11'd2047, 11'd2047, CHK_PREDICT, 11'd0,  11'd0,    1'b0},
      '{OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_PREDICT, 11'd0,  11'd0,    1'b0},
      '{OP_START, 11'd2047, 11'd0,    11'd0,    11'd2047, CHK_PIXEL, 11'd2047, 11'd0,    1'b0},
      '{OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_PREDICT, 11'd0,  11'd0,    1'b0},
      // short horizontal walked to the end and past it
      '{OP_START, 11'd5,    11'd3,    11'd7,    11'd3,    CHK_PIXEL, 11'd5,    11'd3,    1'b0},
      '{OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_PIXEL, 11'd6,    11'd3,    1'b0},
      '{OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_PIXEL, 11'd7,    11'd3,    1'b1},
      '{OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_NONE,  11'd0,    11'd0,    1'b0},
      // one step backward
      '{OP_START, 11'd10,   11'd10,   11'd9,    11'd10,   CHK_PIXEL, 11'd10,   11'd10,   1'b0},
      '{OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_PIXEL, 11'd9,    11'd10,   1'b1},
      // exact half on y rounds up
      '{OP_START, 11'd100,  11'd200,  11'd102,  11'd201,  CHK_PIXEL, 11'd100,  11'd200,  1'b0},
      '{OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_PIXEL, 11'd101,  11'd201,  1'b0},
      '{OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_PIXEL, 11'd102,  11'd201,  1'b1},
      // truncated thirds
      '{OP_START, 11'd100,  11'd200,  11'd103,  11'd201,  CHK_PIXEL, 11'd100,  11'd200,  1'b0},
      '{OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_PREDICT, 11'd0,  11'd0,    1'b0},
      '{OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_PREDICT, 11'd0,  11'd0,    1'b0},
      '{OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_PREDICT, 11'd0,  11'd0,    1'b0},
      // anti-diagonal with a falling y
      '{OP_START, 11'd0,    11'd2047, 11'd2047, 11'd0,    CHK_PIXEL, 11'd0,    11'd2047, 1'b0},
      '{OP_STEP,  11'd0,    11'd0,    11'd0,    11'd0,    CHK_PREDICT, 11'd0,  11'd0,    1'b0}
    };

    // Hold reset, then release it once
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIR; i++) send_item(dir_rows[i], got);

    // Random lines: mostly full walks, some overrun and some cut short
    while (produced_cnt < RAND_PIXELS) begin
      hold_req = (produced_cnt >= 300);
      calm     = (produced_cnt >= 600) && (produced_cnt < 850);

      pick = $urandom_range(0, 99);
      wide = (pick < 8);
      if (wide) begin
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        ex = coord_t'($urandom);
        ey = coord_t'($urandom);
      end else begin
        sx = coord_t'($urandom_range(16, 2031));
        sy = coord_t'($urandom_range(16, 2031));
        if (pick < 13) begin
          ex = sx;
          ey = sy;
        end else begin
          ex = coord_t'(int'(sx) + int'($urandom_range(0, 32)) - 16);
          ey = coord_t'(int'(sy) + int'($urandom_range(0, 32)) - 16);
        end
      end

      // Occasional stray step between lines
      if ($urandom_range(0, 99) < 5) begin
        r = '{OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), CHK_PREDICT, 11'd0, 11'd0, 1'b0};
        send_item(r, got);
        if (got) produced_cnt++;
      end

      r = '{OP_START, sx, sy, ex, ey, CHK_PREDICT, 11'd0, 11'd0, 1'b0};
      send_item(r, got);
      if (got) produced_cnt++;

      dx   = int'(ex) - int'(sx);
      dy   = int'(ey) - int'(sy);
      dx   = dx < 0 ? -dx : dx;
      dy   = dy < 0 ? -dy : dy;
      span = dx > dy ? dx : dy;
      pick = $urandom_range(0, 99);
      if (pick < 70)      walk = span;
      else if (pick < 85) walk = span + $urandom_range(1, 3);
      else                walk = $urandom_range(0, span);
      if (wide && walk > 48) walk = $urandom_range(0, 48);

      for (int s = 0; s < walk; s++) begin
        r = '{OP_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), CHK_PREDICT, 11'd0, 11'd0, 1'b0};
        send_item(r, got);
        if (got) produced_cnt++;
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    // Drain the pipe, then watch for strays
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
